@@ hw/rtl/qat_pkg.sv @@
// Shared types for the quoted argument tokenizer.
`default_nettype none

package qat_pkg;

    // One byte of the callback string with its restart flag.
    typedef struct packed {
        logic [7:0] char_in;
        logic       first_byte;
    } in_item_t;

    // One result beat: an argument byte or an end-of-argument mark.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    // Result kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/qat_in_if.sv @@
// Input stream interface: one string byte per beat.
`default_nettype none

interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       first_byte;

    modport source (output valid, output char_in, output first_byte, input ready);
    modport sink (input valid, input char_in, input first_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qat_out_if.sv @@
// Output stream interface: one argument byte or end mark per beat.
`default_nettype none

interface qat_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qat_input_stage.sv @@
// Input register stage that captures one string byte per beat.
`default_nettype none

module qat_input_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    qat_in_if.sink            in_stream,
    input  wire logic         out_free,
    output logic              item_valid,
    output qat_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    qat_pkg::in_item_t item_reg;
    logic              take;

    // The stage accepts a new byte whenever its current byte moves on.
    assign in_stream.ready = !valid_reg || out_free;
    assign take            = in_stream.valid && in_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_in    <= in_stream.char_in;
            item_reg.first_byte <= in_stream.first_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/qat_parser.sv @@
// Parse phase register and the per-byte decode of the argument list.
`default_nettype none

module qat_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire qat_pkg::in_item_t  item,
    output logic                    has_result,
    output qat_pkg::result_t        result
);

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_PLAIN  = 3'd1,
        PH_QUOTED = 3'd2,
        PH_ESCAPE = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_cur;
    logic [7:0] c;

    assign c = item.char_in;

    // A first byte restarts the parse before the byte itself is handled.
    assign phase_cur = item.first_byte ? PH_SEEK : phase_reg;

    // Decode one byte against the current phase.
    always_comb
    begin
        phase_next   = phase_cur;
        has_result   = 1'b0;
        result.kind  = qat_pkg::KIND_BYTE;
        result.value = c;
        result.last  = 1'b0;
        unique case (phase_cur)
            PH_SEEK:
            begin
                if (c == CH_OPEN)
                begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_PLAIN:
            begin
                priority if (c == CH_SPACE || c == CH_BSLASH)
                begin
                    has_result = 1'b0;
                end
                else if (c == CH_QUOTE)
                begin
                    phase_next = PH_QUOTED;
                end
                else if (c == CH_COMMA)
                begin
                    has_result   = 1'b1;
                    result.kind  = qat_pkg::KIND_END;
                    result.value = 8'h00;
                end
                else if (c == CH_CLOSE)
                begin
                    phase_next   = PH_DONE;
                    has_result   = 1'b1;
                    result.kind  = qat_pkg::KIND_END;
                    result.value = 8'h00;
                    result.last  = 1'b1;
                end
                else
                begin
                    has_result = 1'b1;
                end
            end
            PH_QUOTED:
            begin
                priority if (c == CH_BSLASH)
                begin
                    phase_next = PH_ESCAPE;
                end
                else if (c == CH_QUOTE)
                begin
                    phase_next = PH_PLAIN;
                end
                else
                begin
                    has_result = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                // Known escapes map to control bytes and an escaped quote to a quote; any other byte is dropped.
                phase_next = PH_QUOTED;
                has_result = 1'b1;
                priority case (c)
                    CH_QUOTE: result.value = CH_QUOTE;
                    CH_R:     result.value = CH_CR;
                    CH_N:     result.value = CH_LF;
                    CH_B:     result.value = CH_BS;
                    CH_T:     result.value = CH_TAB;
                    default:  has_result   = 1'b0;
                endcase
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/qat_output_stage.sv @@
// Result register that holds one beat until the sink takes it.
`default_nettype none

module qat_output_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire qat_pkg::result_t  result,
    qat_out_if.source              out_stream,
    output logic                   out_free
);

    logic             valid_reg;
    logic             valid_next;
    qat_pkg::result_t result_reg;

    // The register can take a new beat when empty or when its beat leaves now.
    assign out_free = !valid_reg || out_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_stream.valid = valid_reg;
    assign out_stream.kind  = result_reg.kind;
    assign out_stream.value = result_reg.value;
    assign out_stream.last  = result_reg.last;

endmodule

`default_nettype wire

@@ hw/rtl/quoted_argument_tokenizer_top.sv @@
// Top level of the quoted argument tokenizer.
//
// Channel      Direction  Payload                   Beat
// in_stream    sink       char_in[7:0], first_byte  one string byte
// out_stream   source     kind, value[7:0], last    one argument byte or end mark
//
// One byte is taken every cycle unless the output stalls; a byte with a result goes
// via the input register to the result register; one phase register steps each byte.
// Reset clears the phase to seeking the opening parenthesis and empties both stages.
// A stalled output holds its beat, and the input stage keeps taking bytes
// only as fast as its byte can move on into the result register.
`default_nettype none

module quoted_argument_tokenizer_top (
    input  wire logic clk,
    input  wire logic rst_n,
    qat_in_if.sink    in_stream,
    qat_out_if.source out_stream
);

    logic              item_valid;
    qat_pkg::in_item_t item;
    logic              out_free;
    logic              advance;
    logic              has_result;
    qat_pkg::result_t  result;

    assign advance = item_valid && out_free;

    qat_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .out_free   (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    qat_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    qat_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && has_result),
        .result     (result),
        .out_stream (out_stream),
        .out_free   (out_free)
    );

endmodule

`default_nettype wire

@@ hw/rtl/qat_checker.sv @@
// Port-level checks for the tokenizer and their binding to the top level.
`default_nettype none

module qat_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_kind,
    input wire logic [7:0] out_value,
    input wire logic       out_last
);

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value)
            && $stable(out_last))
        else $error("output payload changed while stalled");

    // A result shown on an empty output comes from an input byte taken through both stage registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_beat, 2))
        else $error("output beat without a matching input beat");

    // End marks carry no byte, and only end marks can close the list.
    a_mark_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind ? (out_value == 8'h00) : !out_last))
        else $error("malformed result beat");

endmodule

bind quoted_argument_tokenizer_top qat_checker u_qat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_kind  (out_stream.kind),
    .out_value (out_stream.value),
    .out_last  (out_stream.last)
);

`default_nettype wire
